// ===== sv/sfc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the steering force combiner.
package sfc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int WORD_W        = 32;
  localparam int REG_W         = 31;
  localparam int SQRT_STEPS    = 32;
  localparam int SUM_W         = 36;
  localparam int CFG_ADDR_W    = 5;
  localparam logic [REG_W-1:0] REG_MAX = 31'h7fff_ffff;

  typedef enum logic [2:0] {
    REG_ENABLE_SEEK,
    REG_ENABLE_ARRIVE,
    REG_ENABLE_PURSUE,
    REG_ENABLE_EVADE,
    REG_ENABLE_FLEE,
    REG_MAX_SPEED,
    REG_MAX_ACCEL,
    REG_LEAD_TIME
  } reg_idx_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] pos_x;
    logic signed [WORD_W-1:0] pos_y;
    logic signed [WORD_W-1:0] vel_x;
    logic signed [WORD_W-1:0] vel_y;
    logic signed [WORD_W-1:0] goal_x;
    logic signed [WORD_W-1:0] goal_y;
    logic signed [WORD_W-1:0] goal_vel_x;
    logic signed [WORD_W-1:0] goal_vel_y;
  } in_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] accel_x;
    logic signed [WORD_W-1:0] accel_y;
  } out_word_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] x;
    logic signed [WORD_W-1:0] y;
  } vec_t;

  // One bit wider, for a direction minus a velocity kept unsaturated
  typedef struct packed {
    logic signed [WORD_W:0] x;
    logic signed [WORD_W:0] y;
  } wvec_t;

  // Clamp to the signed 32-bit range
  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      return 32'sh7fff_ffff;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end
    return v[WORD_W-1:0];
  endfunction

  // Saturating a - b
  function automatic logic signed [WORD_W-1:0] sub_sat(input logic signed [WORD_W-1:0] a,
                                                       input logic signed [WORD_W-1:0] b);
    return sat32(64'(a) - 64'(b));
  endfunction

  // Divide by 2^sh, truncating toward zero
  function automatic logic signed [63:0] div_pow2(input logic signed [63:0] v, input int sh);
    logic signed [63:0] bias;
    bias = v[63] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
    return (v + bias) >>> sh;
  endfunction

endpackage

// ===== sv/sfc_if.sv =====
// Valid/ready channels for agent words and acceleration words.
interface sfc_in_if;
  logic               valid;
  logic               ready;
  sfc_pkg::in_word_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sfc_out_if;
  logic               valid;
  logic               ready;
  sfc_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== sv/steering_force_combiner.sv =====
// Top level: APB registers, behaviour pipelines and the saturating sum.
//
//  channel | dir | handshake      | word
//  item    | in  | valid/ready    | agent pos/vel, goal pos/vel (8 x Q16.16)
//  result  | out | valid/ready    | accel_x, accel_y (Q16.16, saturated)
//  apb     | in  | psel/penable   | 8 registers at 4*index, pready tied high
//
// One word per cycle in and out unless stalled; three chained unit-vector
// units (square root and divider stages) and the travel-time divider set the
// depth. The whole pipeline advances only while the result register is empty
// or being taken, so a stall holds every stage in place. Reset clears valid
// and enable bits and loads register defaults; nothing else needs a sweep.
module steering_force_combiner #(
  parameter int FRAC_BITS = sfc_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  sfc_in_if.sink                         item,
  sfc_out_if.source                      result,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sfc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int SUM_W   = sfc_pkg::SUM_W;
  localparam int VW      = $bits(sfc_pkg::vec_t);
  localparam int WW      = $bits(sfc_pkg::wvec_t);
  localparam int UL      = sfc_pkg::SQRT_STEPS + FRAC_BITS + 5;
  localparam int MAG_LAT = sfc_pkg::SQRT_STEPS + 2;
  localparam int QT      = 32 + FRAC_BITS;
  localparam int S1      = 1;
  localparam int S_T     = S1 + MAG_LAT + QT + 1;
  localparam int S_P     = S_T + 4;
  localparam int S_END   = S_P + 2 + 2 * UL;
  localparam int LAT     = S_END + 2;
  localparam logic [30:0] SPEED_RST = 31'(100 << FRAC_BITS);
  localparam logic [30:0] LEAD_RST  = 31'(1 << FRAC_BITS);

  // Configuration registers
  logic        en_seek, en_arrive, en_pursue, en_evade, en_flee;
  logic [30:0] max_speed, max_accel, lead_time;

  logic                  en;
  logic [LAT:0]          stage_v;
  sfc_pkg::in_word_t     s0_w;

  sfc_pkg::vec_t         d_q, nd_q, dir_a, dir_c, vel1, sd_q, dir_b, seek_e;
  sfc_pkg::wvec_t        arr_q, arr_e, fl_q, flee_e;
  logic [31:0]           mag_a;
  logic [QT-1:0]         quo_t;
  logic [30:0]           t_q, sc_q, t_d2, spd_den;
  logic [61:0]           tl_prod;
  sfc_pkg::vec_t         gv_d, g_d, p_d, pred_p, pred_e, pdiff_q, ediff_q;
  logic signed [63:0]    pp_x, pp_y, pe_x, pe_y;
  sfc_pkg::vec_t         dir_d, dir_f, vel2, ed_q, dir_e;
  sfc_pkg::wvec_t        ev_q, ev_e;
  logic signed [SUM_W-1:0] sum_x, sum_y, sum_x_q, sum_y_q;
  sfc_pkg::out_word_t    out_q;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      en_seek   <= 1'b0;
      en_arrive <= 1'b0;
      en_pursue <= 1'b0;
      en_evade  <= 1'b0;
      en_flee   <= 1'b0;
      max_speed <= SPEED_RST;
      max_accel <= SPEED_RST;
      lead_time <= LEAD_RST;
    end else if (psel && penable && pwrite) begin
      case (sfc_pkg::reg_idx_t'(paddr[4:2]))
        sfc_pkg::REG_ENABLE_SEEK:   en_seek   <= pwdata[0];
        sfc_pkg::REG_ENABLE_ARRIVE: en_arrive <= pwdata[0];
        sfc_pkg::REG_ENABLE_PURSUE: en_pursue <= pwdata[0];
        sfc_pkg::REG_ENABLE_EVADE:  en_evade  <= pwdata[0];
        sfc_pkg::REG_ENABLE_FLEE:   en_flee   <= pwdata[0];
        sfc_pkg::REG_MAX_SPEED:     max_speed <= pwdata[30:0];
        sfc_pkg::REG_MAX_ACCEL:     max_accel <= pwdata[30:0];
        sfc_pkg::REG_LEAD_TIME:     lead_time <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (sfc_pkg::reg_idx_t'(paddr[4:2]))
      sfc_pkg::REG_ENABLE_SEEK:   prdata = {31'd0, en_seek};
      sfc_pkg::REG_ENABLE_ARRIVE: prdata = {31'd0, en_arrive};
      sfc_pkg::REG_ENABLE_PURSUE: prdata = {31'd0, en_pursue};
      sfc_pkg::REG_ENABLE_EVADE:  prdata = {31'd0, en_evade};
      sfc_pkg::REG_ENABLE_FLEE:   prdata = {31'd0, en_flee};
      sfc_pkg::REG_MAX_SPEED:     prdata = {1'b0, max_speed};
      sfc_pkg::REG_MAX_ACCEL:     prdata = {1'b0, max_accel};
      sfc_pkg::REG_LEAD_TIME:     prdata = {1'b0, lead_time};
      default:                    prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Pipeline advance: move unless the result register holds an untaken word
  assign en         = !stage_v[LAT] || result.ready;
  assign item.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= '0;
    end else if (en) begin
      stage_v <= {stage_v[LAT-1:0], item.valid};
    end
  end

  // Capture the input word, then differences and arrive
  always_ff @(posedge clk) begin
    if (en) begin
      s0_w    <= item.data;
      d_q.x   <= sfc_pkg::sub_sat(s0_w.goal_x, s0_w.pos_x);
      d_q.y   <= sfc_pkg::sub_sat(s0_w.goal_y, s0_w.pos_y);
      nd_q.x  <= sfc_pkg::sub_sat(s0_w.pos_x, s0_w.goal_x);
      nd_q.y  <= sfc_pkg::sub_sat(s0_w.pos_y, s0_w.goal_y);
      arr_q.x <= 33'(sfc_pkg::div_pow2(64'(sfc_pkg::sub_sat(s0_w.goal_x, s0_w.pos_x)), 1)
                     - 64'(s0_w.vel_x));
      arr_q.y <= 33'(sfc_pkg::div_pow2(64'(sfc_pkg::sub_sat(s0_w.goal_y, s0_w.pos_y)), 1)
                     - 64'(s0_w.vel_y));
    end
  end

  // Desired direction toward and away from the goal
  sfc_unit #(.FRAC_BITS(FRAC_BITS)) u_unit_a (
    .clk(clk), .en(en), .vec(d_q), .scale(max_speed), .dir(dir_a), .mag(mag_a)
  );

  sfc_unit #(.FRAC_BITS(FRAC_BITS)) u_unit_c (
    .clk(clk), .en(en), .vec(nd_q), .scale(max_speed), .dir(dir_c), .mag()
  );

  sfc_delay #(.W(VW), .N(S1 + UL)) u_vel1 (
    .clk(clk), .en(en), .d({s0_w.vel_x, s0_w.vel_y}), .q(vel1)
  );

  // Seek steering vector and flee acceleration
  always_ff @(posedge clk) begin
    if (en) begin
      sd_q.x <= sfc_pkg::sub_sat(dir_a.x, vel1.x);
      sd_q.y <= sfc_pkg::sub_sat(dir_a.y, vel1.y);
      fl_q.x <= 33'(64'(dir_c.x) - 64'(vel1.x));
      fl_q.y <= 33'(64'(dir_c.y) - 64'(vel1.y));
    end
  end

  sfc_unit #(.FRAC_BITS(FRAC_BITS)) u_unit_b (
    .clk(clk), .en(en), .vec(sd_q), .scale(max_accel), .dir(dir_b), .mag()
  );

  // Travel time: distance over max speed, capped
  assign spd_den = (max_speed == 31'd0) ? 31'd1 : max_speed;

  sfc_div #(.NW(QT), .DW(31), .QW(QT)) u_div_t (
    .clk(clk), .en(en), .num({mag_a, {FRAC_BITS{1'b0}}}), .den(spd_den), .quo(quo_t)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      t_q     <= (quo_t > QT'(sfc_pkg::REG_MAX)) ? sfc_pkg::REG_MAX : quo_t[30:0];
      tl_prod <= t_q * lead_time;
      sc_q    <= (|tl_prod[61:FRAC_BITS+31]) ? sfc_pkg::REG_MAX
                                              : tl_prod[FRAC_BITS+30:FRAC_BITS];
    end
  end

  sfc_delay #(.W(31), .N(2)) u_t_dly (.clk(clk), .en(en), .d(t_q), .q(t_d2));

  sfc_delay #(.W(VW), .N(S_T + 2)) u_gv_dly (
    .clk(clk), .en(en), .d({s0_w.goal_vel_x, s0_w.goal_vel_y}), .q(gv_d)
  );

  sfc_delay #(.W(VW), .N(S_T + 3)) u_g_dly (
    .clk(clk), .en(en), .d({s0_w.goal_x, s0_w.goal_y}), .q(g_d)
  );

  // Predicted goal for pursue and evade
  always_ff @(posedge clk) begin
    if (en) begin
      pp_x     <= gv_d.x * $signed({1'b0, sc_q});
      pp_y     <= gv_d.y * $signed({1'b0, sc_q});
      pe_x     <= gv_d.x * $signed({1'b0, t_d2});
      pe_y     <= gv_d.y * $signed({1'b0, t_d2});
      pred_p.x <= sfc_pkg::sat32(64'(g_d.x)
                  + 64'(sfc_pkg::sat32(sfc_pkg::div_pow2(pp_x, FRAC_BITS))));
      pred_p.y <= sfc_pkg::sat32(64'(g_d.y)
                  + 64'(sfc_pkg::sat32(sfc_pkg::div_pow2(pp_y, FRAC_BITS))));
      pred_e.x <= sfc_pkg::sat32(64'(g_d.x)
                  + 64'(sfc_pkg::sat32(sfc_pkg::div_pow2(pe_x, FRAC_BITS))));
      pred_e.y <= sfc_pkg::sat32(64'(g_d.y)
                  + 64'(sfc_pkg::sat32(sfc_pkg::div_pow2(pe_y, FRAC_BITS))));
    end
  end

  sfc_delay #(.W(VW), .N(S_P)) u_p_dly (
    .clk(clk), .en(en), .d({s0_w.pos_x, s0_w.pos_y}), .q(p_d)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      pdiff_q.x <= sfc_pkg::sub_sat(pred_p.x, p_d.x);
      pdiff_q.y <= sfc_pkg::sub_sat(pred_p.y, p_d.y);
      ediff_q.x <= sfc_pkg::sub_sat(p_d.x, pred_e.x);
      ediff_q.y <= sfc_pkg::sub_sat(p_d.y, pred_e.y);
    end
  end

  sfc_unit #(.FRAC_BITS(FRAC_BITS)) u_unit_d (
    .clk(clk), .en(en), .vec(pdiff_q), .scale(max_speed), .dir(dir_d), .mag()
  );

  sfc_unit #(.FRAC_BITS(FRAC_BITS)) u_unit_f (
    .clk(clk), .en(en), .vec(ediff_q), .scale(max_speed), .dir(dir_f), .mag()
  );

  sfc_delay #(.W(VW), .N(S_P + 1 + UL)) u_vel2 (
    .clk(clk), .en(en), .d({s0_w.vel_x, s0_w.vel_y}), .q(vel2)
  );

  // Pursue steering vector and evade acceleration
  always_ff @(posedge clk) begin
    if (en) begin
      ed_q.x <= sfc_pkg::sub_sat(dir_d.x, vel2.x);
      ed_q.y <= sfc_pkg::sub_sat(dir_d.y, vel2.y);
      ev_q.x <= 33'(64'(dir_f.x) - 64'(vel2.x));
      ev_q.y <= 33'(64'(dir_f.y) - 64'(vel2.y));
    end
  end

  sfc_unit #(.FRAC_BITS(FRAC_BITS)) u_unit_e (
    .clk(clk), .en(en), .vec(ed_q), .scale(max_accel), .dir(dir_e), .mag()
  );

  // Align every behaviour to the sum stage
  sfc_delay #(.W(WW), .N(UL)) u_ev_dly (.clk(clk), .en(en), .d(ev_q), .q(ev_e));
  sfc_delay #(.W(VW), .N(S_END - S1 - 2 * UL - 1)) u_seek_dly (
    .clk(clk), .en(en), .d(dir_b), .q(seek_e)
  );
  sfc_delay #(.W(WW), .N(S_END - S1 - UL - 1)) u_flee_dly (
    .clk(clk), .en(en), .d(fl_q), .q(flee_e)
  );
  sfc_delay #(.W(WW), .N(S_END - S1)) u_arr_dly (
    .clk(clk), .en(en), .d(arr_q), .q(arr_e)
  );

  // Sum enabled behaviours at full width
  assign sum_x = (en_seek   ? SUM_W'(seek_e.x) : '0) + (en_arrive ? SUM_W'(arr_e.x) : '0)
               + (en_pursue ? SUM_W'(dir_e.x)  : '0) + (en_evade  ? SUM_W'(ev_e.x)  : '0)
               + (en_flee   ? SUM_W'(flee_e.x) : '0);
  assign sum_y = (en_seek   ? SUM_W'(seek_e.y) : '0) + (en_arrive ? SUM_W'(arr_e.y) : '0)
               + (en_pursue ? SUM_W'(dir_e.y)  : '0) + (en_evade  ? SUM_W'(ev_e.y)  : '0)
               + (en_flee   ? SUM_W'(flee_e.y) : '0);

  // Sum register, then saturate into the result register
  always_ff @(posedge clk) begin
    if (en) begin
      sum_x_q       <= sum_x;
      sum_y_q       <= sum_y;
      out_q.accel_x <= sfc_pkg::sat32(64'(sum_x_q));
      out_q.accel_y <= sfc_pkg::sat32(64'(sum_y_q));
    end
  end

  assign result.valid = stage_v[LAT];
  assign result.data  = out_q;

  // An accepted word enters the first stage
  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> stage_v[0])
    else $error("accepted word did not enter the pipeline");

  // A word in the last stage before the result register moves out on advance
  a_last_moves: assert property (@(posedge clk) disable iff (rst)
    en && stage_v[LAT-1] |=> stage_v[LAT])
    else $error("word lost before the result register");

  // A stall freezes every valid bit
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(stage_v))
    else $error("pipeline moved during a stall");

endmodule

// ===== sv/sfc_delay.sv =====
// Enable-gated shift line that keeps side data in step with the pipeline.
module sfc_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [N];

  // Advance every tap on enable
  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < N; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[N-1];

endmodule

// ===== sv/sfc_isqrt.sv =====
// Pipelined floor square root of a 64-bit radicand, one root bit per stage.
module sfc_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rad,
  output logic [31:0] root
);

  localparam int STEPS = sfc_pkg::SQRT_STEPS;

  logic [63:0] rem_q  [STEPS];
  logic [31:0] root_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam int BIT = STEPS - 1 - k;
    logic [63:0] rin;
    logic [31:0] qin;
    logic [64:0] trial;

    if (k == 0) begin : g_first
      assign rin = rad;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_q[k-1];
      assign qin = root_q[k-1];
    end

    // (root + 2^BIT)^2 - root^2
    assign trial = ({33'd0, qin} << (BIT + 1)) + (65'd1 << (2 * BIT));

    // Keep the bit when the remainder covers the trial
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rin} >= trial) begin
          rem_q[k]  <= rin - trial[63:0];
          root_q[k] <= qin | (32'd1 << BIT);
        end else begin
          rem_q[k]  <= rin;
          root_q[k] <= qin;
        end
      end
    end
  end

  assign root = root_q[STEPS-1];

endmodule

// ===== sv/sfc_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module sfc_div #(
  parameter int NW = 48,
  parameter int DW = 32,
  parameter int QW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  // Caller guarantees num >> QW < den
  logic [DW+QW-1:0] acc_q [QW];
  logic [DW-1:0]    den_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW+QW-1:0] ain;
    logic [DW-1:0]    din;
    logic [DW:0]      trial;

    if (k == 0) begin : g_first
      assign ain = {DW'(num >> QW), num[QW-1:0]};
      assign din = den;
    end else begin : g_next
      assign ain = acc_q[k-1];
      assign din = den_q[k-1];
    end

    assign trial = ain[DW+QW-1:QW-1];

    // Subtract when it fits, shift the quotient bit in
    always_ff @(posedge clk) begin
      if (en) begin
        den_q[k] <= din;
        if (trial >= {1'b0, din}) begin
          acc_q[k] <= {DW'(trial - {1'b0, din}), ain[QW-2:0], 1'b1};
        end else begin
          acc_q[k] <= {trial[DW-1:0], ain[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = acc_q[QW-1][QW-1:0];

endmodule

// ===== sv/sfc_unit.sv =====
// Unit vector of a 2D vector scaled by a gain: square, root, divide, multiply.
module sfc_unit #(
  parameter int FRAC_BITS = sfc_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          en,
  input  sfc_pkg::vec_t vec,
  input  logic [30:0]   scale,
  output sfc_pkg::vec_t dir,
  output logic [31:0]   mag
);

  localparam int QW      = FRAC_BITS + 1;
  localparam int NW      = 32 + FRAC_BITS;
  localparam int MAG_LAT = sfc_pkg::SQRT_STEPS + 2;

  logic [31:0]      abs_x, abs_y;
  logic [63:0]      sq_x, sq_y, rad;
  logic [31:0]      root, den;
  logic [31:0]      abs_x_d, abs_y_d;
  logic [QW-1:0]    quo_x, quo_y;
  logic [1:0]       sgn_d;
  logic [QW+30:0]   prod_x, prod_y;
  logic [31:0]      sm_x, sm_y;

  assign abs_x = vec.x[31] ? (32'd0 - vec.x) : vec.x;
  assign abs_y = vec.y[31] ? (32'd0 - vec.y) : vec.y;

  // Square and sum
  always_ff @(posedge clk) begin
    if (en) begin
      sq_x <= abs_x * abs_x;
      sq_y <= abs_y * abs_y;
      rad  <= sq_x + sq_y;
    end
  end

  sfc_isqrt u_isqrt (.clk(clk), .en(en), .rad(rad), .root(root));

  assign mag = root;

  sfc_delay #(.W(64), .N(MAG_LAT)) u_abs_dly (
    .clk(clk), .en(en), .d({abs_x, abs_y}), .q({abs_x_d, abs_y_d})
  );

  sfc_delay #(.W(2), .N(MAG_LAT + QW + 1)) u_sgn_dly (
    .clk(clk), .en(en), .d({vec.x[31], vec.y[31]}), .q(sgn_d)
  );

  // A zero length only comes from a zero vector, so any nonzero divisor gives zero
  assign den = (root == 32'd0) ? 32'd1 : root;

  sfc_div #(.NW(NW), .DW(32), .QW(QW)) u_div_x (
    .clk(clk), .en(en), .num({abs_x_d, {FRAC_BITS{1'b0}}}), .den(den), .quo(quo_x)
  );

  sfc_div #(.NW(NW), .DW(32), .QW(QW)) u_div_y (
    .clk(clk), .en(en), .num({abs_y_d, {FRAC_BITS{1'b0}}}), .den(den), .quo(quo_y)
  );

  assign sm_x = prod_x[QW+30:FRAC_BITS];
  assign sm_y = prod_y[QW+30:FRAC_BITS];

  // Scale, drop fraction bits, restore sign
  always_ff @(posedge clk) begin
    if (en) begin
      prod_x <= quo_x * scale;
      prod_y <= quo_y * scale;
      dir.x  <= sgn_d[1] ? (32'd0 - sm_x) : sm_x;
      dir.y  <= sgn_d[0] ? (32'd0 - sm_y) : sm_y;
    end
  end

endmodule
